// ===== src/u2u8_pkg.sv =====
// Package for the UTF-16 to UTF-8 transcoder: types, codes, encoder function.
package u2u8_pkg;

  localparam int unsigned QDepthDefault = 2;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_ERROR = 2'd1,
    KIND_END   = 2'd2
  } kind_e;

  // one classified item waiting for the back end
  typedef struct packed {
    kind_e       kind;
    logic [20:0] cp;
    logic [1:0]  nbytes_m1;
    logic        str_end;
  } job_t;

  function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] n_m1,
                                           input logic [1:0] idx);
    logic [7:0] b;
    b = 8'h00;
    unique case (n_m1)
      2'd0: b = {1'b0, cp[6:0]};
      2'd1: b = (idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
      2'd2: begin
        unique case (idx)
          2'd0:    b = {4'b1110, cp[15:12]};
          2'd1:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      default: begin
        unique case (idx)
          2'd0: b = {5'b11110, cp[20:18]};
          2'd1: b = {2'b10, cp[17:12]};
          2'd2: b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
    endcase
    return b;
  endfunction

endpackage

// ===== src/utf16_to_utf8_transcoder.sv =====
// Top level of the UTF-16 to UTF-8 transcoder.
//  channel | direction | handshake               | payload
//  in      | input     | in_valid_i / in_stall_o   | code_unit_i, last_unit_i
//  out     | output    | out_valid_o / out_stall_i | kind_o, byte_value_o, last_of_run_o,
//          |           |                           | string_end_o
// An item causes 1 to 4 bytes, one error or end result, or none for a held high
// surrogate or a dropped unit. The back end's single output register, one byte per
// cycle while out_stall_i is low, sets the rate; the front takes a unit per cycle while
// the job queue has room. Reset clears surrogate state, queue and output valid.
// Output stall backs up through the queue to in_stall_o.
module utf16_to_utf8_transcoder import u2u8_pkg::*; #(
  parameter int unsigned QDepth = QDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] code_unit_i,
  input  logic        last_unit_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  byte_value_o,
  output logic        last_of_run_o,
  output logic        string_end_o
);

  logic q_full, push, q_valid, pop;
  job_t job_in, head;

  u2u8_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .code_unit_i, .last_unit_i,
    .q_full_i(q_full), .push_o(push), .job_o(job_in)
  );

  u2u8_queue #(.Depth(QDepth)) u_queue (
    .clk_i, .rst_ni, .push_i(push), .job_i(job_in), .full_o(q_full),
    .valid_o(q_valid), .head_o(head), .pop_i(pop)
  );

  u2u8_back u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_head_i(head), .pop_o(pop),
    .out_valid_o, .out_stall_i, .kind_o, .byte_value_o, .last_of_run_o, .string_end_o
  );

endmodule

// ===== src/u2u8_front.sv =====
// Front end: accepts code units, tracks surrogate state, classifies into jobs.
module u2u8_front import u2u8_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] code_unit_i,
  input  logic        last_unit_i,
  input  logic        q_full_i,
  output logic        push_o,
  output job_t        job_o
);

  logic [9:0] held_q, held_d;
  logic       pending_q, pending_d;
  logic       failed_q, failed_d;
  logic       accept, is_high, is_low, want_push;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign is_high    = (code_unit_i[15:10] == 6'b110110);
  assign is_low     = (code_unit_i[15:10] == 6'b110111);
  assign push_o     = accept && want_push;

  always_comb begin
    held_d          = held_q;
    pending_d       = pending_q;
    failed_d        = failed_q;
    want_push       = 1'b0;
    job_o.kind      = KIND_DATA;
    job_o.cp        = {5'd0, code_unit_i};
    job_o.nbytes_m1 = 2'd0;
    job_o.str_end   = last_unit_i;
    if (failed_q) begin
      if (last_unit_i) begin
        want_push  = 1'b1;
        job_o.kind = KIND_END;
        failed_d   = 1'b0;
      end
    end else if (pending_q && !is_low) begin
      want_push  = 1'b1;
      job_o.kind = KIND_ERROR;
      held_d     = '0;
      pending_d  = 1'b0;
      failed_d   = !last_unit_i;
    end else if (pending_q) begin
      want_push       = 1'b1;
      job_o.cp        = {1'b0, held_q, code_unit_i[9:0]} + 21'h10000;
      job_o.nbytes_m1 = 2'd3;
      held_d          = '0;
      pending_d       = 1'b0;
    end else if (is_low || (is_high && last_unit_i)) begin
      want_push  = 1'b1;
      job_o.kind = KIND_ERROR;
      failed_d   = !last_unit_i;
    end else if (is_high) begin
      held_d    = code_unit_i[9:0];
      pending_d = 1'b1;
    end else begin
      want_push = 1'b1;
      if (code_unit_i < 16'h0080) begin
        job_o.nbytes_m1 = 2'd0;
      end else if (code_unit_i < 16'h0800) begin
        job_o.nbytes_m1 = 2'd1;
      end else begin
        job_o.nbytes_m1 = 2'd2;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q    <= '0;
      pending_q <= 1'b0;
      failed_q  <= 1'b0;
    end else if (accept) begin
      held_q    <= held_d;
      pending_q <= pending_d;
      failed_q  <= failed_d;
    end
  end

endmodule

// ===== src/u2u8_queue.sv =====
// Job queue between front and back end.
module u2u8_queue import u2u8_pkg::*; #(
  parameter int unsigned Depth = QDepthDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  output logic valid_o,
  output job_t head_o,
  input  logic pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== src/u2u8_back.sv =====
// Back end: expands the head job into result items, one per cycle while the output is not stalled.
module u2u8_back import u2u8_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  job_t       q_head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] kind_o,
  output logic [7:0] byte_value_o,
  output logic       last_of_run_o,
  output logic       string_end_o
);

  logic [1:0] idx_q;
  logic       valid_q;
  logic [1:0] kind_q;
  logic [7:0] byte_q;
  logic       lor_q, send_q;
  logic       advance, final_one;

  assign advance   = q_valid_i && (!valid_q || !out_stall_i);
  assign final_one = (idx_q == q_head_i.nbytes_m1);
  assign pop_o     = advance && final_one;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      if (advance) begin
        valid_q <= 1'b1;
        idx_q   <= final_one ? 2'd0 : idx_q + 1'b1;
      end else if (!out_stall_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      kind_q <= q_head_i.kind;
      byte_q <= (q_head_i.kind == KIND_DATA) ?
                utf8_byte(q_head_i.cp, q_head_i.nbytes_m1, idx_q) : 8'h00;
      lor_q  <= final_one;
      send_q <= final_one && q_head_i.str_end;
    end
  end

  assign out_valid_o   = valid_q;
  assign kind_o        = kind_q;
  assign byte_value_o  = byte_q;
  assign last_of_run_o = lor_q;
  assign string_end_o  = send_q;

endmodule

// ===== src/u2u8_checker.sv =====
// Port-level checker for the transcoder, bound to the top level.
module u2u8_checker import u2u8_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] kind_o,
  input logic [7:0] byte_value_o,
  input logic       last_of_run_o,
  input logic       string_end_o
);

  a_nondata_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != KIND_DATA |-> byte_value_o == 8'h00)
    else $error("error or end item carries a nonzero byte");

  a_end_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_END |-> string_end_o && last_of_run_o)
    else $error("end marker not flagged as string end");

  a_send_lor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && string_end_o |-> last_of_run_o)
    else $error("string end without last of run");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o)
      && $stable(byte_value_o) && $stable(last_of_run_o) && $stable(string_end_o))
    else $error("stalled output item changed");

endmodule

bind utf16_to_utf8_transcoder u2u8_checker u_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
  .kind_o(kind_o), .byte_value_o(byte_value_o), .last_of_run_o(last_of_run_o),
  .string_end_o(string_end_o)
);
